// File: hdl/rtsook_pkg.sv
// shared types and constants for the toggle-frame ook transmitter
`timescale 1ns / 1ps

package rtsook_pkg;

  // frame layout
  localparam int unsigned FRAME_BITS = 80;
  localparam logic [7:0]  FRAME_KEY = 8'hA4;
  localparam logic [7:0]  FRAME_MARK = 8'hF0;
  localparam logic [7:0]  EXT_BASE = 8'd196;
  localparam logic [7:0]  EXT_B9_FLAG = 8'h10;
  localparam logic [4:0]  EXT_WRAP = 5'd15;

  // operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_START = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOL = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_WAKE_HI = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_WAKE_LO = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SOFT_HI = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_SYNC = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_SYNC = 3'd6;

  // configuration reset values
  localparam logic [11:0] SYMBOL_RST = 12'd640;
  localparam logic [15:0] WAKE_HI_RST = 16'd10920;
  localparam logic [15:0] WAKE_LO_RST = 16'd7357;
  localparam logic [15:0] SOFT_HI_RST = 16'd4850;
  localparam logic [3:0]  FIRST_SYNC_RST = 4'd12;
  localparam logic [3:0]  REPEAT_SYNC_RST = 4'd6;

  // input word
  typedef struct packed {
    logic        operation;
    logic [23:0] remote_id;
    logic [15:0] rolling_code;
    logic [4:0]  repeat_count;
  } in_word_t;

  // result word
  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic start_accepted;
    logic done_res;
  } out_word_t;

endpackage

// File: hdl/rts_toggle_frame_ook_transmitter.sv
// toggle-frame ook transmitter: frame builder, segment timer and manchester keyer
// the result word of an accepted input word is registered in the output register
// throughput: one word per cycle while out_ready is high; a result held back blocks in_ready
// while busy, each tick word advances the line one microsecond via one segment logic pass
// reset (rst_n low, synchronous): idle, no result pending, config registers at reset values
`timescale 1ns / 1ps

module rts_toggle_frame_ook_transmitter #(
  parameter int unsigned TICK_COUNTER_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  rtsook_pkg::in_word_t                  in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output rtsook_pkg::out_word_t                 out_data,
  input  logic                                  cfg_we,
  input  logic [rtsook_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rtsook_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned TCW = TICK_COUNTER_WIDTH;
  localparam logic [23:0] TICK_CAP = 24'((1 << TCW) - 1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAKE_HI,
    PH_WAKE_LO,
    PH_SYNC_HI,
    PH_SYNC_LO,
    PH_SOFT_HI,
    PH_SOFT_LO,
    PH_DATA
  } phase_t;

  typedef struct packed {
    phase_t         phase;
    logic           half;
    logic [TCW-1:0] tick;
    logic [3:0]     pulse;
    logic [6:0]     bit_idx;
    logic [4:0]     fidx;
  } tx_state_t;

  // state after a segment step, with end-of-transmission flag
  typedef struct packed {
    logic      fin;
    tx_state_t st;
  } step_t;

  // configuration view used by the segment logic
  typedef struct packed {
    logic       sym_zero;
    logic       wh_zero;
    logic       wl_zero;
    logic       sh_zero;
    logic [3:0] first_cnt;
    logic [3:0] repeat_cnt;
    logic [4:0] total;
  } ctx_t;

  // configuration registers
  logic        en_r;
  logic [11:0] sym_r;
  logic [15:0] wake_hi_r;
  logic [15:0] wake_lo_r;
  logic [15:0] soft_hi_r;
  logic [3:0]  first_sync_r;
  logic [3:0]  repeat_sync_r;

  // transmission state
  tx_state_t st_r, st_nxt;
  logic [4:0]  total_r, total_nxt;
  logic [55:0] frame_r, frame_nxt;

  // output register
  logic                  out_valid_r;
  rtsook_pkg::out_word_t out_data_r;
  rtsook_pkg::out_word_t res;

  logic     in_accept;
  ctx_t     cx;
  step_t    n1, adv, n2;
  logic [15:0]    len_raw;
  logic [23:0]    len_wide;
  logic [TCW-1:0] seg_len;
  logic [TCW-1:0] tick_inc;
  logic           seg_level;
  logic [rtsook_pkg::FRAME_BITS-1:0] frame_vec;
  logic [7:0] ext_b7_v;
  logic [7:0] ext_b9_v;
  logic [7:0] bytes_in [7];
  logic [7:0] bytes_ob [7];
  logic [3:0] csum;

  // sync pulse count of the frame in progress
  function automatic logic [3:0] sync_cnt(logic [4:0] fi, ctx_t c);
    return (fi == 5'd0) ? c.first_cnt : c.repeat_cnt;
  endfunction

  // extension byte 7 for a given frame number
  function automatic logic [7:0] ext_b7(logic [4:0] fi);
    logic [4:0] m;
    if (fi >= 5'(2 * rtsook_pkg::EXT_WRAP)) begin
      m = fi - 5'(2 * rtsook_pkg::EXT_WRAP);
    end else if (fi >= rtsook_pkg::EXT_WRAP) begin
      m = fi - rtsook_pkg::EXT_WRAP;
    end else begin
      m = fi;
    end
    return rtsook_pkg::EXT_BASE + {2'b00, m[3:0], 2'b00};
  endfunction

  // skip every zero-length segment from the given state
  function automatic step_t skip_empty(tx_state_t s, ctx_t c);
    step_t r;
    logic  to_sync;
    logic  to_soft;
    logic  to_fend;
    r.fin = 1'b0;
    r.st = s;
    to_sync = 1'b0;
    to_soft = 1'b0;
    to_fend = 1'b0;
    unique case (s.phase)
      PH_WAKE_HI: begin
        if (c.wh_zero) begin
          if (c.wl_zero) begin
            to_sync = 1'b1;
          end else begin
            r.st.phase = PH_WAKE_LO;
            r.st.tick = '0;
          end
        end
      end
      PH_WAKE_LO: begin
        if (c.wl_zero) to_sync = 1'b1;
      end
      PH_SYNC_HI, PH_SYNC_LO: begin
        if (c.sym_zero) to_soft = 1'b1;
      end
      PH_SOFT_HI: begin
        if (c.sh_zero) begin
          if (!c.sym_zero) begin
            r.st.phase = PH_SOFT_LO;
            r.st.tick = '0;
          end else begin
            to_fend = 1'b1;
          end
        end
      end
      PH_SOFT_LO, PH_DATA: begin
        if (c.sym_zero) to_fend = 1'b1;
      end
      default: ;
    endcase
    // entering the hardware sync of the current frame
    if (to_sync) begin
      r.st.pulse = '0;
      r.st.tick = '0;
      if (sync_cnt(s.fidx, c) != 4'd0 && !c.sym_zero) begin
        r.st.phase = PH_SYNC_HI;
      end else begin
        to_soft = 1'b1;
      end
    end
    // software sync, or its low half when the high time is zero
    if (to_soft) begin
      r.st.tick = '0;
      if (!c.sh_zero) begin
        r.st.phase = PH_SOFT_HI;
      end else if (!c.sym_zero) begin
        r.st.phase = PH_SOFT_LO;
      end else begin
        to_fend = 1'b1;
      end
    end
    // zero-length data: the frame ends at once
    if (to_fend) begin
      r.st.tick = '0;
      r.st.bit_idx = '0;
      r.st.half = 1'b0;
      r.st.pulse = '0;
      if (s.fidx < c.total && !c.sh_zero) begin
        r.st.fidx = s.fidx + 5'd1;
        r.st.phase = PH_SOFT_HI;
      end else begin
        r.st.phase = PH_IDLE;
        r.fin = 1'b1;
      end
    end
    return r;
  endfunction

  // move to the next segment after a finished one
  function automatic step_t advance(tx_state_t s, ctx_t c);
    step_t      r;
    logic [3:0] p;
    r.fin = 1'b0;
    r.st = s;
    r.st.tick = '0;
    p = s.pulse + 4'd1;
    unique case (s.phase)
      PH_WAKE_HI: r.st.phase = PH_WAKE_LO;
      PH_WAKE_LO: begin
        r.st.pulse = '0;
        r.st.phase = (sync_cnt(s.fidx, c) != 4'd0) ? PH_SYNC_HI : PH_SOFT_HI;
      end
      PH_SYNC_HI: r.st.phase = PH_SYNC_LO;
      PH_SYNC_LO: begin
        r.st.pulse = p;
        r.st.phase = (p != 4'd0 && p < sync_cnt(s.fidx, c)) ? PH_SYNC_HI : PH_SOFT_HI;
      end
      PH_SOFT_HI: r.st.phase = PH_SOFT_LO;
      PH_SOFT_LO: begin
        r.st.phase = PH_DATA;
        r.st.bit_idx = '0;
        r.st.half = 1'b0;
      end
      PH_DATA: begin
        if (!s.half) begin
          r.st.half = 1'b1;
        end else begin
          r.st.half = 1'b0;
          if (s.bit_idx == 7'(rtsook_pkg::FRAME_BITS - 1)) begin
            r.st.bit_idx = '0;
            if (s.fidx < c.total) begin
              r.st.fidx = s.fidx + 5'd1;
              r.st.pulse = '0;
              r.st.phase = (sync_cnt(s.fidx + 5'd1, c) != 4'd0) ? PH_SYNC_HI : PH_SOFT_HI;
            end else begin
              r.st.phase = PH_IDLE;
              r.fin = 1'b1;
            end
          end else begin
            r.st.bit_idx = s.bit_idx + 7'd1;
          end
        end
      end
      default: begin
        r.st.phase = PH_IDLE;
        r.fin = 1'b1;
      end
    endcase
    return r;
  endfunction

  assign in_ready = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  // configuration view
  always_comb begin
    cx.sym_zero = (sym_r == 12'd0);
    cx.wh_zero = (wake_hi_r == 16'd0);
    cx.wl_zero = (wake_lo_r == 16'd0);
    cx.sh_zero = (soft_hi_r == 16'd0);
    cx.first_cnt = first_sync_r;
    cx.repeat_cnt = repeat_sync_r;
    cx.total = total_r;
  end

  // state with empty segments skipped
  assign n1 = skip_empty(st_r, cx);

  // length of the current segment, saturated to the tick counter
  always_comb begin
    unique case (n1.st.phase)
      PH_WAKE_HI:           len_raw = wake_hi_r;
      PH_WAKE_LO:           len_raw = wake_lo_r;
      PH_SYNC_HI, PH_SYNC_LO: len_raw = {2'b00, sym_r, 2'b00};
      PH_SOFT_HI:           len_raw = soft_hi_r;
      PH_SOFT_LO, PH_DATA:  len_raw = {4'h0, sym_r};
      default:              len_raw = 16'd0;
    endcase
    len_wide = ({8'h00, len_raw} > TICK_CAP) ? TICK_CAP : {8'h00, len_raw};
    seg_len = len_wide[TCW-1:0];
  end

  // full frame with extension bytes for the frame in progress
  always_comb begin
    ext_b7_v = ext_b7(n1.st.fidx);
    ext_b9_v = rtsook_pkg::EXT_B9_FLAG
             | {4'h0, ext_b7_v[7:4] ^ ext_b7_v[3:0] ^ {3'b000, n1.st.fidx != 5'd0}};
    frame_vec = {frame_r, ext_b7_v, 8'h00, ext_b9_v};
  end

  // line level of the current segment
  always_comb begin
    unique case (n1.st.phase)
      PH_WAKE_HI, PH_SYNC_HI, PH_SOFT_HI: seg_level = 1'b1;
      PH_DATA: seg_level = frame_vec[7'(rtsook_pkg::FRAME_BITS - 1) - n1.st.bit_idx]
                         ^ n1.st.half ^ 1'b1;
      default: seg_level = 1'b0;
    endcase
  end

  // frame build for a start word
  always_comb begin
    bytes_in[0] = rtsook_pkg::FRAME_KEY;
    bytes_in[1] = rtsook_pkg::FRAME_MARK;
    bytes_in[2] = in_data.rolling_code[15:8];
    bytes_in[3] = in_data.rolling_code[7:0];
    bytes_in[4] = in_data.remote_id[23:16];
    bytes_in[5] = in_data.remote_id[15:8];
    bytes_in[6] = in_data.remote_id[7:0];
    csum = 4'h0;
    for (int i = 0; i < 7; i++) begin
      csum = csum ^ bytes_in[i][7:4] ^ bytes_in[i][3:0];
    end
    bytes_in[1] = bytes_in[1] | {4'h0, csum};
    // chained obfuscation
    bytes_ob[0] = bytes_in[0];
    for (int i = 1; i < 7; i++) begin
      bytes_ob[i] = bytes_in[i] ^ bytes_ob[i-1];
    end
  end

  // next state and result word
  always_comb begin
    st_nxt = st_r;
    total_nxt = total_r;
    frame_nxt = frame_r;
    res = '0;
    tick_inc = n1.st.tick + TCW'(1);
    adv = advance(n1.st, cx);
    n2 = skip_empty(adv.st, cx);
    if (in_data.operation == rtsook_pkg::OP_START) begin
      if (en_r && st_r.phase == PH_IDLE) begin
        frame_nxt = {bytes_ob[0], bytes_ob[1], bytes_ob[2], bytes_ob[3],
                     bytes_ob[4], bytes_ob[5], bytes_ob[6]};
        total_nxt = in_data.repeat_count;
        st_nxt = '0;
        st_nxt.phase = PH_WAKE_HI;
        res.start_accepted = 1'b1;
      end
    end else if (st_r.phase != PH_IDLE) begin
      if (n1.fin) begin
        st_nxt = n1.st;
        res.done_res = 1'b1;
      end else begin
        res.line_level = seg_level;
        if (tick_inc >= seg_len) begin
          if (adv.fin) begin
            st_nxt = adv.st;
            res.done_res = 1'b1;
          end else begin
            st_nxt = n2.st;
            res.done_res = n2.fin;
          end
        end else begin
          st_nxt = n1.st;
          st_nxt.tick = tick_inc;
        end
      end
    end
    res.busy_res = (st_nxt.phase != PH_IDLE);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b0;
      sym_r <= rtsook_pkg::SYMBOL_RST;
      wake_hi_r <= rtsook_pkg::WAKE_HI_RST;
      wake_lo_r <= rtsook_pkg::WAKE_LO_RST;
      soft_hi_r <= rtsook_pkg::SOFT_HI_RST;
      first_sync_r <= rtsook_pkg::FIRST_SYNC_RST;
      repeat_sync_r <= rtsook_pkg::REPEAT_SYNC_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rtsook_pkg::CFG_ENABLE:      en_r <= cfg_data[0];
        rtsook_pkg::CFG_SYMBOL:      sym_r <= cfg_data[11:0];
        rtsook_pkg::CFG_WAKE_HI:     wake_hi_r <= cfg_data;
        rtsook_pkg::CFG_WAKE_LO:     wake_lo_r <= cfg_data;
        rtsook_pkg::CFG_SOFT_HI:     soft_hi_r <= cfg_data;
        rtsook_pkg::CFG_FIRST_SYNC:  first_sync_r <= cfg_data[3:0];
        rtsook_pkg::CFG_REPEAT_SYNC: repeat_sync_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // transmission state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
      total_r <= '0;
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      st_r <= st_nxt;
      total_r <= total_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // frame payload and result word
  always_ff @(posedge clk) begin
    if (in_accept) begin
      frame_r <= frame_nxt;
      out_data_r <= res;
    end
  end

  // a finished transmission leaves the block idle
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.done_res |-> !out_data_r.busy_res)
    else $error("done result reports busy");

  // an accepted start keys nothing and leaves the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.start_accepted |->
      out_data_r.busy_res && !out_data_r.line_level && !out_data_r.done_res)
    else $error("start result inconsistent");

  // the tick counter is cleared whenever the block is idle
  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_IDLE |-> st_r.tick == '0)
    else $error("tick counter left running while idle");

  // the data bit index stays inside the frame
  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_DATA |-> st_r.bit_idx < 7'(rtsook_pkg::FRAME_BITS))
    else $error("bit index past end of frame");

  // the frame number never passes the repeat count
  a_frame_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase != PH_IDLE |-> st_r.fidx <= total_r)
    else $error("frame number past repeat count");

endmodule
